>>> hw/rtl/kst_pkg.sv
// Shared types, scan codes and translation tables for the keyboard scan-code translator.
// No dependencies; every other file takes names from here by scope.
package kst_pkg;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bytes to and from the keyboard
    localparam logic [7:0] LED_CMD      = 8'hED;
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_TAB       = 8'h0F;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_SCROLL    = 8'h45;
    localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
    localparam logic [7:0] SC_ACK       = 8'hFA;
    localparam logic [7:0] SC_RESEND    = 8'hFE;

    typedef enum logic [1:0] {
        KEY_EV_NONE      = 2'd0,
        KEY_EV_BACKSPACE = 2'd1,
        KEY_EV_ENTER     = 2'd2,
        KEY_EV_FOCUS     = 2'd3
    } kst_key_ev_t;

    // Control from the decoder to the command queue
    typedef struct packed {
        logic restart;
        logic step;
        logic push_pair;
        logic pop_allowed;
    } kst_q_ctrl_t;

    // Status from the command queue
    typedef struct packed {
        logic       pop_valid;
        logic [7:0] pop_byte;
    } kst_q_stat_t;

    // Set 1 make code to ASCII, Japanese layout, no shift
    localparam logic [6:0] PLAIN_MAP [128] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h5E, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h40, 7'h5B, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
        7'h3A, 7'h00, 7'h00, 7'h5D, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h5C, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5C, 7'h00, 7'h00
    };

    // Same with either shift held
    localparam logic [6:0] SHIFTED_MAP [128] = '{
        7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
        7'h27, 7'h28, 7'h29, 7'h7E, 7'h3D, 7'h7E, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h60, 7'h7B, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h2B,
        7'h2A, 7'h00, 7'h00, 7'h7D, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h5F, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7C, 7'h00, 7'h00
    };

endpackage

>>> hw/rtl/kst_char_xlate.sv
// Scan code to ASCII character lookup with caps-lock and shift case folding.
// Depends on kst_pkg for the translation tables.
module kst_char_xlate (
    input  logic [7:0] code,
    input  logic       shift_active,
    input  logic       caps_on,
    output logic [6:0] char_out
);

    logic [6:0] raw_char;
    logic       is_upper;

    // Look up make codes only; break codes and replies give no character
    always_comb
    begin
        if (code[7])
        begin
            raw_char = 7'h00;
        end
        else if (shift_active)
        begin
            raw_char = kst_pkg::SHIFTED_MAP[code[6:0]];
        end
        else
        begin
            raw_char = kst_pkg::PLAIN_MAP[code[6:0]];
        end
    end

    // Lower a letter unless exactly one of caps lock and shift is active
    assign is_upper = (raw_char >= 7'h41) && (raw_char <= 7'h5A);
    assign char_out = (is_upper && (caps_on == shift_active)) ? (raw_char + 7'h20) : raw_char;

endmodule

>>> hw/rtl/kst_cmd_queue.sv
// Command byte queue towards the keyboard: pushes LED command pairs, pops at most one byte a step.
// Depends on kst_pkg for queue geometry, the LED command byte and the control structs.
module kst_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  kst_pkg::kst_q_ctrl_t ctrl,
    input  logic [2:0]          leds,
    output kst_pkg::kst_q_stat_t stat
);

    logic [7:0]                 mem_reg [kst_pkg::QUEUE_DEPTH];
    logic [kst_pkg::QCNT_W-1:0] count_reg;
    logic [kst_pkg::QCNT_W-1:0] count_next;
    logic [kst_pkg::QPTR_W-1:0] head_reg;
    logic [kst_pkg::QPTR_W-1:0] head_next;
    logic [kst_pkg::QCNT_W-1:0] count_pushed;
    logic [kst_pkg::QPTR_W-1:0] wr_addr_a;
    logic [kst_pkg::QPTR_W-1:0] wr_addr_b;
    logic                       push_a;
    logic                       push_b;
    logic                       pop;

    // Drop each byte on its own when the queue is full
    assign push_a = ctrl.push_pair && (count_reg < kst_pkg::QCNT_W'(kst_pkg::QUEUE_DEPTH));
    assign push_b = ctrl.push_pair && (count_reg < kst_pkg::QCNT_W'(kst_pkg::QUEUE_DEPTH - 1));

    assign wr_addr_a = head_reg + count_reg[kst_pkg::QPTR_W-1:0];
    assign wr_addr_b = wr_addr_a + kst_pkg::QPTR_W'(1);

    assign count_pushed = count_reg + kst_pkg::QCNT_W'(push_a) + kst_pkg::QCNT_W'(push_b);

    // Pop after this step's pushes; an empty queue hands over the command just pushed
    assign pop            = ctrl.pop_allowed && (count_pushed != '0);
    assign stat.pop_valid = pop;
    assign stat.pop_byte  = (count_reg == '0) ? kst_pkg::LED_CMD : mem_reg[head_reg];

    assign head_next  = pop ? (head_reg + kst_pkg::QPTR_W'(1)) : head_reg;
    assign count_next = count_pushed - kst_pkg::QCNT_W'(pop);

    // Pointers: restart holds the LED command and LED byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= kst_pkg::QCNT_W'(2);
            head_reg  <= '0;
        end
        else if (ctrl.restart)
        begin
            count_reg <= kst_pkg::QCNT_W'(2);
            head_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // Storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kst_pkg::QUEUE_DEPTH; i++)
            begin
                mem_reg[i] <= (i == 0) ? kst_pkg::LED_CMD : 8'h00;
            end
        end
        else if (ctrl.restart)
        begin
            mem_reg[0] <= kst_pkg::LED_CMD;
            mem_reg[1] <= {5'b0, leds};
        end
        else if (ctrl.step)
        begin
            if (push_a)
            begin
                mem_reg[wr_addr_a] <= kst_pkg::LED_CMD;
            end
            if (push_b)
            begin
                mem_reg[wr_addr_b] <= {5'b0, leds};
            end
        end
    end

endmodule

>>> hw/rtl/keyboard_scancode_translator.sv
// Top level of the keyboard scan-code translator: input register, decode, result register.
// Depends on kst_pkg, kst_char_xlate and kst_cmd_queue.
//
// Takes one set 1 scan-code byte per transfer and returns exactly one result per byte:
// the translated character (Japanese layout), a key event, the focus bit, the LED
// state and, when due, the command byte sent to the keyboard. Throughput is one byte
// per clock unless the receiver stalls; a byte sits in the input register, then in the
// result register, with all decoding, LED and queue updates in the single stage between
// them. The input accepts a byte whenever the input register is empty or moves on,
// and it moves on whenever the result register is empty or its result is taken.
// A write on cfg_we loads the start LED state and returns the decode state and the
// 32-entry command queue to their start state at once; bytes held in the registers stay.
module keyboard_scancode_translator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       char_valid,
    output logic [6:0] char_code,
    output logic [1:0] key_event,
    output logic       focus,
    output logic [2:0] led_state,
    output logic       send_valid,
    output logic [7:0] send_byte
);

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_code_reg;

    // Block state
    logic [1:0] shift_reg;
    logic [1:0] shift_next;
    logic [2:0] led_reg;
    logic [2:0] led_next;
    logic       focus_reg;
    logic       focus_next;
    logic       ack_reg;
    logic       ack_next;
    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    // Result register
    logic                 out_valid_reg;
    logic                 char_valid_reg;
    logic [6:0]           char_code_reg;
    kst_pkg::kst_key_ev_t key_event_reg;
    kst_pkg::kst_key_ev_t key_event_next;
    logic                 focus_out_reg;
    logic [2:0]           led_out_reg;
    logic                 send_valid_reg;
    logic                 send_valid_next;
    logic [7:0]           send_byte_reg;
    logic [7:0]           send_byte_next;

    logic                 out_advance;
    logic                 step_fire;
    logic [6:0]           xlate_char;
    logic                 ack_mid;
    logic                 pend_clear;
    logic                 resend;
    logic                 push_pair;
    kst_pkg::kst_q_ctrl_t q_ctrl;
    kst_pkg::kst_q_stat_t q_stat;

    // Handshake: the result register frees when empty or taken
    assign out_advance = !out_valid_reg || out_ready;
    assign step_fire   = s1_valid_reg && out_advance;
    assign in_ready    = !s1_valid_reg || out_advance;

    // Hold the accepted byte until it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_code_reg <= scan_code;
        end
    end

    // Character lookup against the state before this byte
    kst_char_xlate u_xlate (
        .code         (s1_code_reg),
        .shift_active (|shift_reg),
        .caps_on      (led_reg[2]),
        .char_out     (xlate_char)
    );

    // Decode the byte: shift, locks, focus, acknowledge and resend
    always_comb
    begin
        shift_next     = shift_reg;
        led_next       = led_reg;
        focus_next     = focus_reg;
        ack_mid        = ack_reg;
        pend_clear     = 1'b0;
        resend         = 1'b0;
        push_pair      = 1'b0;
        key_event_next = kst_pkg::KEY_EV_NONE;
        unique case (s1_code_reg)
            kst_pkg::SC_BACKSPACE: key_event_next = kst_pkg::KEY_EV_BACKSPACE;
            kst_pkg::SC_ENTER:     key_event_next = kst_pkg::KEY_EV_ENTER;
            kst_pkg::SC_TAB:
            begin
                key_event_next = kst_pkg::KEY_EV_FOCUS;
                focus_next     = !focus_reg;
            end
            kst_pkg::SC_LSHIFT:    shift_next = shift_reg | 2'b01;
            kst_pkg::SC_RSHIFT:    shift_next = shift_reg | 2'b10;
            kst_pkg::SC_LSHIFT_BR: shift_next = shift_reg & 2'b10;
            kst_pkg::SC_RSHIFT_BR: shift_next = shift_reg & 2'b01;
            kst_pkg::SC_CAPS:
            begin
                led_next  = led_reg ^ 3'b100;
                push_pair = 1'b1;
            end
            kst_pkg::SC_SCROLL:
            begin
                led_next  = led_reg ^ 3'b001;
                push_pair = 1'b1;
            end
            kst_pkg::SC_ACK:
            begin
                ack_mid    = 1'b0;
                pend_clear = 1'b1;
            end
            kst_pkg::SC_RESEND:    resend = ack_reg;
            default:               ;
        endcase
    end

    // Queue control
    assign q_ctrl.restart     = cfg_we;
    assign q_ctrl.step        = step_fire;
    assign q_ctrl.push_pair   = push_pair;
    assign q_ctrl.pop_allowed = !ack_mid;

    kst_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .leds  (cfg_we ? cfg_wdata : led_next),
        .stat  (q_stat)
    );

    // Send a queued byte when nothing is pending, else resend on request
    always_comb
    begin
        if (q_stat.pop_valid)
        begin
            ack_next        = 1'b1;
            pend_next       = q_stat.pop_byte;
            send_valid_next = 1'b1;
            send_byte_next  = q_stat.pop_byte;
        end
        else
        begin
            ack_next        = ack_mid;
            pend_next       = pend_clear ? 8'h00 : pend_reg;
            send_valid_next = resend;
            send_byte_next  = resend ? pend_reg : 8'h00;
        end
    end

    // Advance block state once per byte; a configuration write restarts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 2'b00;
            led_reg   <= 3'b000;
            focus_reg <= 1'b0;
            ack_reg   <= 1'b0;
            pend_reg  <= 8'h00;
        end
        else if (cfg_we)
        begin
            shift_reg <= 2'b00;
            led_reg   <= cfg_wdata;
            focus_reg <= 1'b0;
            ack_reg   <= 1'b0;
            pend_reg  <= 8'h00;
        end
        else if (step_fire)
        begin
            shift_reg <= shift_next;
            led_reg   <= led_next;
            focus_reg <= focus_next;
            ack_reg   <= ack_next;
            pend_reg  <= pend_next;
        end
    end

    // Result register: load on step, drop once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            char_valid_reg <= (xlate_char != 7'h00);
            char_code_reg  <= xlate_char;
            key_event_reg  <= key_event_next;
            focus_out_reg  <= focus_next;
            led_out_reg    <= led_next;
            send_valid_reg <= send_valid_next;
            send_byte_reg  <= send_byte_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign key_event  = key_event_reg;
    assign focus      = focus_out_reg;
    assign led_state  = led_out_reg;
    assign send_valid = send_valid_reg;
    assign send_byte  = send_byte_reg;

    // A byte taken from the queue becomes the pending byte
    a_pop_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && q_stat.pop_valid && !cfg_we)
        |=> (ack_reg && (pend_reg == $past(q_stat.pop_byte))))
        else $error("popped command byte not left pending");

    // A resend never pops the queue and repeats the pending byte
    a_resend_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && resend) |-> (!q_stat.pop_valid && (send_byte_next == pend_reg)))
        else $error("resend mixed with a queue pop");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

>>> tb/kst_translation_checker.sv
// Result checker for the keyboard scan-code translator: watches both channels and the
// LED start register, predicts every result and compares it field by field.
// Depends on kst_pkg for the scan codes, the LED command byte and the key event type.
module kst_translation_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] scan_code,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       char_valid,
    input  logic [6:0] char_code,
    input  logic [1:0] key_event,
    input  logic       focus,
    input  logic [2:0] led_state,
    input  logic       send_valid,
    input  logic [7:0] send_byte,
    output int         fail_count,
    output int         results_waiting,
    output int         results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 char_valid;
        logic [6:0]           char_code;
        kst_pkg::kst_key_ev_t key_event;
        logic                 focus;
        logic [2:0]           led_state;
        logic                 send_valid;
        logic [7:0]           send_byte;
    } key_result_t;

    // Keyboard state as the block should hold it
    logic [1:0]  shift_held;
    logic [2:0]  led_now;
    logic        focus_now;
    logic        ack_wait;
    logic [7:0]  unacked_byte;
    logic [7:0]  led_cmds [$];
    key_result_t due_results [$];

    // Japanese layout, "z" marks a code with no character
    function automatic logic [6:0] key_char(input logic [6:0] code, input logic shifted);
        string keys;
        byte   c;
        if (shifted)
            keys = {"zz!\"#$%&'()~=~zz", "QWERTYUIOP`{zzAS", "DFGHJKL+*zz}ZXCV",
                    "BNM<>?z*z zzzzzz", "zzzzzzz789-456+1", "230.zzzzzzzzzzzz",
                    "zzzzzzzzzzzzzzzz", "zzz_zzzzzzzzz|zz"};
        else
            keys = {"zz1234567890-^zz", "QWERTYUIOP@[zzAS", "DFGHJKL;:zz]ZXCV",
                    "BNM,./z*z zzzzzz", "zzzzzzz789-456+1", "230.zzzzzzzzzzzz",
                    "zzzzzzzzzzzzzzzz", "zzz\\zzzzzzzzz\\zz"};
        c = keys[code];
        return (c == "z") ? 7'd0 : c[6:0];
    endfunction

    // Drop the byte when the command queue is full
    task automatic queue_cmd(input logic [7:0] b);
        if (led_cmds.size() < kst_pkg::QUEUE_DEPTH)
            led_cmds.push_back(b);
    endtask

    task automatic restart_keyboard(input logic [2:0] leds);
        shift_held   = 2'b00;
        led_now      = leds;
        focus_now    = 1'b0;
        ack_wait     = 1'b0;
        unacked_byte = 8'h00;
        led_cmds.delete();
        queue_cmd(kst_pkg::LED_CMD);
        queue_cmd({5'b0, leds});
    endtask

    // Decode one byte, then send the head of the queue if nothing awaits an acknowledge
    task automatic translate_code(input logic [7:0] code, output key_result_t r);
        logic [6:0] ch;
        ch = 7'd0;
        r  = '0;
        r.key_event = kst_pkg::KEY_EV_NONE;
        if (!code[7])
        begin
            ch = key_char(code[6:0], shift_held != 2'b00);
            if (ch >= "A" && ch <= "Z" && (led_now[2] == (shift_held != 2'b00)))
                ch = ch + 7'h20;
        end
        case (code)
            kst_pkg::SC_BACKSPACE: r.key_event = kst_pkg::KEY_EV_BACKSPACE;
            kst_pkg::SC_ENTER:     r.key_event = kst_pkg::KEY_EV_ENTER;
            kst_pkg::SC_TAB:
            begin
                r.key_event = kst_pkg::KEY_EV_FOCUS;
                focus_now   = ~focus_now;
            end
            kst_pkg::SC_LSHIFT:    shift_held[0] = 1'b1;
            kst_pkg::SC_RSHIFT:    shift_held[1] = 1'b1;
            kst_pkg::SC_LSHIFT_BR: shift_held[0] = 1'b0;
            kst_pkg::SC_RSHIFT_BR: shift_held[1] = 1'b0;
            kst_pkg::SC_CAPS:
            begin
                led_now[2] = ~led_now[2];
                queue_cmd(kst_pkg::LED_CMD);
                queue_cmd({5'b0, led_now});
            end
            kst_pkg::SC_SCROLL:
            begin
                led_now[0] = ~led_now[0];
                queue_cmd(kst_pkg::LED_CMD);
                queue_cmd({5'b0, led_now});
            end
            kst_pkg::SC_ACK:
            begin
                ack_wait     = 1'b0;
                unacked_byte = 8'h00;
            end
            kst_pkg::SC_RESEND:
            begin
                // ignore a resend with nothing outstanding
                if (ack_wait)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = unacked_byte;
                end
            end
            default: ;
        endcase
        if (!ack_wait && led_cmds.size() > 0)
        begin
            unacked_byte = led_cmds.pop_front();
            ack_wait     = 1'b1;
            r.send_valid = 1'b1;
            r.send_byte  = unacked_byte;
        end
        r.char_valid = (ch != 7'd0);
        r.char_code  = ch;
        r.focus      = focus_now;
        r.led_state  = led_now;
    endtask

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    // Compare result transfers first, then predict the byte taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        if (!rst_n)
        begin
            restart_keyboard(3'd0);
            due_results.delete();
            results_waiting <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no result outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("char_valid", want.char_valid, char_valid);
                    check_field("char_code", want.char_code, char_code);
                    check_field("key_event", want.key_event, key_event);
                    check_field("focus", want.focus, focus);
                    check_field("led_state", want.led_state, led_state);
                    check_field("send_valid", want.send_valid, send_valid);
                    check_field("send_byte", want.send_byte, send_byte);
                    results_checked++;
                end
            end
            if (cfg_we)
                restart_keyboard(cfg_wdata);
            if (in_valid && in_ready)
            begin
                translate_code(scan_code, want);
                due_results.push_back(want);
            end
            results_waiting <= due_results.size();
        end
    end

endmodule

>>> tb/tb_keyboard_scancode_translator.sv
// Testbench top for the keyboard scan-code translator: clock, reset, scan-code stimulus,
// receiver pacing and the verdict. Depends on kst_pkg, the translator RTL and
// kst_translation_checker, which does all prediction and comparison.
module tb_keyboard_scancode_translator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_OPENING   = 29;

    // Extremes, both shifts, locks, acknowledge and resend, events and break codes
    localparam logic [7:0] OPENING_CODES [N_OPENING] = '{
        8'h1E, kst_pkg::SC_ACK, kst_pkg::SC_ACK, kst_pkg::SC_RESEND,
        kst_pkg::SC_LSHIFT, 8'h1E, 8'h02, 8'h7D,
        kst_pkg::SC_RSHIFT, kst_pkg::SC_LSHIFT_BR, 8'h73, kst_pkg::SC_RSHIFT_BR,
        kst_pkg::SC_CAPS, 8'h10, kst_pkg::SC_RESEND,
        kst_pkg::SC_ACK, kst_pkg::SC_LSHIFT, 8'h10, kst_pkg::SC_LSHIFT_BR,
        kst_pkg::SC_ACK, kst_pkg::SC_SCROLL, kst_pkg::SC_BACKSPACE,
        kst_pkg::SC_ENTER, kst_pkg::SC_TAB, kst_pkg::SC_TAB, 8'h00, 8'h7F, 8'h80, 8'hFF
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_wdata = 3'd0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] scan_code = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       char_valid;
    logic [6:0] char_code;
    logic [1:0] key_event;
    logic       focus;
    logic [2:0] led_state;
    logic       send_valid;
    logic [7:0] send_byte;

    int fail_count;
    int results_waiting;
    int results_checked;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int codes_sent     = 0;
    int settings_used  = 1;
    int cycle_count    = 0;
    bit hold_reader    = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    keyboard_scancode_translator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scan_code  (scan_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_valid (char_valid),
        .char_code  (char_code),
        .key_event  (key_event),
        .focus      (focus),
        .led_state  (led_state),
        .send_valid (send_valid),
        .send_byte  (send_byte)
    );

    kst_translation_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .scan_code       (scan_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .char_valid      (char_valid),
        .char_code       (char_code),
        .key_event       (key_event),
        .focus           (focus),
        .led_state       (led_state),
        .send_valid      (send_valid),
        .send_byte       (send_byte),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .results_checked (results_checked)
    );

    // Offer one byte, hold it until the transfer, then idle at random
    task automatic offer_code(input logic [7:0] code);
        in_valid  <= 1'b1;
        scan_code <= code;
        do @(posedge clk); while (!in_ready);
        codes_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold the sender until every outstanding result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start_leds(input logic [2:0] leds);
        cfg_we    <= 1'b1;
        cfg_wdata <= leds;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [7:0] lock_code();
        return $urandom_range(1) ? kst_pkg::SC_CAPS : kst_pkg::SC_SCROLL;
    endfunction

    // Mostly keyboard-like traffic with acknowledges, plus fully random bytes
    function automatic logic [7:0] typed_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)      return 8'($urandom_range(8'h7F));
        else if (pick < 42) return {1'b1, 7'($urandom_range(8'h7F))};
        else if (pick < 52)
        begin
            case ($urandom_range(3))
                0:       return kst_pkg::SC_LSHIFT;
                1:       return kst_pkg::SC_RSHIFT;
                2:       return kst_pkg::SC_LSHIFT_BR;
                default: return kst_pkg::SC_RSHIFT_BR;
            endcase
        end
        else if (pick < 58) return lock_code();
        else if (pick < 73) return kst_pkg::SC_ACK;
        else if (pick < 78) return kst_pkg::SC_RESEND;
        else if (pick < 85)
        begin
            case ($urandom_range(2))
                0:       return kst_pkg::SC_BACKSPACE;
                1:       return kst_pkg::SC_ENTER;
                default: return kst_pkg::SC_TAB;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // Random stream with occasional lock bursts that can fill the command queue
    task automatic run_traffic(input int n_codes);
        int left;
        int burst;
        left = n_codes;
        while (left > 0)
        begin
            if ($urandom_range(99) < 3)
            begin
                burst = $urandom_range(12, 20);
                repeat (burst) offer_code(lock_code());
                left -= burst;
            end
            else
            begin
                offer_code(typed_code());
                left--;
            end
        end
    endtask

    // Receiver pacing, with a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_reader)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_reader = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abandon a run that stops making progress
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("keyboard_scancode_translator test failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening sequence with the reset LED state
        send_idle_pct = 23;
        recv_idle_pct = 81;
        for (int i = 0; i < N_OPENING; i++)
            offer_code(OPENING_CODES[i]);
        wait_drained();

        // All LEDs on; fill the queue, free one slot, then lock again
        write_start_leds(3'd7);
        repeat (16) offer_code(lock_code());
        offer_code(kst_pkg::SC_ACK);
        offer_code(kst_pkg::SC_SCROLL);
        offer_code(kst_pkg::SC_RESEND);
        run_traffic(460);
        wait_drained();

        write_start_leds(3'd0);
        send_idle_pct = 81;
        recv_idle_pct = 23;
        run_traffic(460);
        wait_drained();

        // Back-to-back, with the receiver held off while bytes keep coming
        write_start_leds(3'($urandom_range(1, 6)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reader   = 1'b1;
        run_traffic(460);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d scan codes under %0d LED start settings, %0d results checked",
                 codes_sent, settings_used, results_checked);
        if (fail_count == 0)
            $display("keyboard_scancode_translator test passed");
        else
            $display("keyboard_scancode_translator test failed");
        $finish;
    end

endmodule
